// ===== hw/rtl/lcr_pkg.sv =====
// shared types and constants for the load cell adc serial reader
package lcr_pkg;

    typedef struct packed {
        logic [1:0] action;
        logic       dout_level;
    } t_in;

    typedef struct packed {
        logic               sck_level;
        logic               result_valid;
        logic signed [23:0] raw_value;
        logic signed [31:0] weight_value;
        logic               timed_out;
        logic               busy_res;
    } t_out;

    typedef struct packed {
        logic [1:0]         gain_pulses;
        logic [19:0]        timeout_ticks;
        logic [7:0]         half_period_ticks;
        logic signed [31:0] scale_reciprocal;
    } t_cfg;

    typedef struct packed {
        logic               sck;
        logic               done;
        logic               tmo;
        logic               busy;
        logic signed [23:0] raw;
    } t_flags;

    localparam logic [1:0] ACT_TICK       = 2'd0;
    localparam logic [1:0] ACT_READ       = 2'd1;
    localparam logic [1:0] ACT_TARE       = 2'd2;
    localparam logic [1:0] ACT_POWER_DOWN = 2'd3;

    localparam logic [1:0] REG_GAIN_PULSES   = 2'd0;
    localparam logic [1:0] REG_TIMEOUT_TICKS = 2'd1;
    localparam logic [1:0] REG_HALF_PERIOD   = 2'd2;
    localparam logic [1:0] REG_SCALE_RECIP   = 2'd3;

    localparam logic [1:0]         RST_GAIN_PULSES   = 2'd1;
    localparam logic [19:0]        RST_TIMEOUT_TICKS = 20'd100000;
    localparam logic [7:0]         RST_HALF_PERIOD   = 8'd1;
    localparam logic signed [31:0] RST_SCALE_RECIP   = 32'sd65536;

    localparam logic signed [31:0] WEIGHT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] WEIGHT_MIN = 32'sh8000_0000;

endpackage

// ===== hw/rtl/lcr_regs.sv =====
// configuration registers
module lcr_regs import lcr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_pulses       <= RST_GAIN_PULSES;
            r_cfg.timeout_ticks     <= RST_TIMEOUT_TICKS;
            r_cfg.half_period_ticks <= RST_HALF_PERIOD;
            r_cfg.scale_reciprocal  <= RST_SCALE_RECIP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GAIN_PULSES:   r_cfg.gain_pulses       <= i_cfg_data[1:0];
                REG_TIMEOUT_TICKS: r_cfg.timeout_ticks     <= i_cfg_data[19:0];
                REG_HALF_PERIOD:   r_cfg.half_period_ticks <= i_cfg_data[7:0];
                REG_SCALE_RECIP:   r_cfg.scale_reciprocal  <= signed'(i_cfg_data);
                default:           r_cfg                   <= r_cfg;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

// ===== hw/rtl/lcr_ctrl.sv =====
// pin sequencer: wait for ready, clock data and gain pulses, tare offset
module lcr_ctrl import lcr_pkg::*; #(
    parameter int DATA_BITS = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic                 i_en,
    input  t_in                  i_item,
    input  t_cfg                 i_cfg,
    output t_flags               o_flags,
    output logic signed [DATA_BITS:0] o_diff
);

    localparam int CW = $clog2(DATA_BITS + 4);

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_WAIT = 4'b0010,
        PH_HIGH = 4'b0100,
        PH_LOW  = 4'b1000
    } t_phase;

    t_phase                      r_phase, n_phase;
    logic [CW-1:0]               r_bit_count, n_bit_count;
    logic [DATA_BITS-1:0]        r_shift, n_shift;
    logic [19:0]                 r_wait, n_wait;
    logic [7:0]                  r_half, n_half;
    logic signed [DATA_BITS-1:0] r_offset, n_offset;
    logic                        r_tare, n_tare;
    logic                        r_clk, n_clk;
    t_flags                      r_flags, n_flags;
    logic signed [DATA_BITS:0]   r_diff, n_diff;

    logic [7:0]                  hp;
    logic [8:0]                  half_inc;
    logic                        half_hit;
    logic [CW-1:0]               bit_inc;
    logic [CW-1:0]               bit_limit;
    logic [19:0]                 wait_inc;
    logic                        done;
    logic                        tmo;
    logic signed [DATA_BITS-1:0] raw;
    logic signed [31:0]          raw32;

    assign hp        = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign half_inc  = {1'b0, r_half} + 9'd1;
    assign half_hit  = half_inc >= {1'b0, hp};
    assign bit_inc   = r_bit_count + CW'(1);
    assign bit_limit = CW'(DATA_BITS) + CW'(i_cfg.gain_pulses);
    assign wait_inc  = r_wait + 20'd1;

    always_comb begin
        n_phase     = r_phase;
        n_bit_count = r_bit_count;
        n_shift     = r_shift;
        n_wait      = r_wait;
        n_half      = r_half;
        n_offset    = r_offset;
        n_tare      = r_tare;
        n_clk       = r_clk;
        done        = 1'b0;
        tmo         = 1'b0;
        raw         = '0;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_item.action == ACT_READ || i_item.action == ACT_TARE) begin
                    n_phase = PH_WAIT;
                    n_wait  = '0;
                    n_tare  = (i_item.action == ACT_TARE);
                    n_clk   = 1'b0;
                end else if (i_item.action == ACT_POWER_DOWN) begin
                    n_clk = 1'b1;
                end
            end
            PH_WAIT: begin
                if (!i_item.dout_level) begin
                    n_phase     = PH_HIGH;
                    n_bit_count = '0;
                    n_shift     = '0;
                    n_half      = '0;
                    n_clk       = 1'b1;
                end else begin
                    n_wait = wait_inc;
                    if (wait_inc >= i_cfg.timeout_ticks) begin
                        done = 1'b1;
                        tmo  = 1'b1;
                    end
                end
            end
            PH_HIGH: begin
                n_half = half_inc[7:0];
                if (half_hit) begin
                    if (r_bit_count < CW'(DATA_BITS)) begin
                        n_shift = {r_shift[DATA_BITS-2:0], i_item.dout_level};
                    end
                    n_half  = '0;
                    n_clk   = 1'b0;
                    n_phase = PH_LOW;
                end
            end
            PH_LOW: begin
                n_half = half_inc[7:0];
                if (half_hit) begin
                    n_half      = '0;
                    n_bit_count = bit_inc;
                    if (bit_inc < bit_limit) begin
                        n_clk   = 1'b1;
                        n_phase = PH_HIGH;
                    end else begin
                        done = 1'b1;
                        raw  = signed'(r_shift);
                    end
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase
        if (done) begin
            n_phase = PH_IDLE;
            n_clk   = 1'b0;
            if (r_tare) begin
                n_offset = raw;
            end
            n_tare = 1'b0;
        end
    end

    assign raw32 = 32'(raw);

    always_comb begin
        n_flags.sck  = n_clk;
        n_flags.done = done;
        n_flags.tmo  = tmo;
        n_flags.busy = (n_phase != PH_IDLE);
        n_flags.raw  = signed'(raw32[23:0]);
        n_diff       = r_tare ? '0 : ((DATA_BITS + 1)'(raw) - (DATA_BITS + 1)'(r_offset));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_bit_count <= '0;
            r_shift     <= '0;
            r_wait      <= '0;
            r_half      <= '0;
            r_offset    <= '0;
            r_tare      <= 1'b0;
            r_clk       <= 1'b0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_bit_count <= n_bit_count;
            r_shift     <= n_shift;
            r_wait      <= n_wait;
            r_half      <= n_half;
            r_offset    <= n_offset;
            r_tare      <= n_tare;
            r_clk       <= n_clk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= n_flags;
            r_diff  <= n_diff;
        end
    end

    assign o_flags = r_flags;
    assign o_diff  = r_diff;

endmodule

// ===== hw/rtl/lcr_scale.sv =====
// weight scaling: split multiply, floor shift by 16, saturate
module lcr_scale import lcr_pkg::*; #(
    parameter int DATA_BITS = 24
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  t_flags                    i_flags,
    input  logic signed [DATA_BITS:0] i_diff,
    input  logic signed [31:0]        i_scale,
    output t_out                      o_data
);

    logic signed [32:0] d33;
    logic signed [16:0] lo;
    logic signed [16:0] hi;
    logic signed [48:0] n_plo, r_plo;
    logic signed [48:0] n_phi, r_phi;
    t_flags             r_flags;
    logic signed [49:0] q;
    logic signed [31:0] sat;
    t_out               n_out, r_out;

    assign d33   = 33'(i_diff);
    assign lo    = signed'({1'b0, d33[15:0]});
    assign hi    = signed'(d33[32:16]);
    assign n_plo = 49'(lo) * 49'(i_scale);
    assign n_phi = 49'(hi) * 49'(i_scale);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_flags <= i_flags;
            r_plo   <= n_plo;
            r_phi   <= n_phi;
        end
    end

    assign q = 50'(r_phi) + 50'(r_plo >>> 16);

    always_comb begin
        priority if (q > 50'(WEIGHT_MAX)) begin
            sat = WEIGHT_MAX;
        end else if (q < 50'(WEIGHT_MIN)) begin
            sat = WEIGHT_MIN;
        end else begin
            sat = q[31:0];
        end
        n_out.sck_level    = r_flags.sck;
        n_out.result_valid = r_flags.done;
        n_out.raw_value    = r_flags.raw;
        n_out.weight_value = r_flags.done ? sat : '0;
        n_out.timed_out    = r_flags.tmo;
        n_out.busy_res     = r_flags.busy;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

endmodule

// ===== hw/rtl/load_cell_adc_serial_reader.sv =====
// load cell adc serial reader top level
// each accepted tick passes the sequencer, multiply and saturate registers in turn to its result
// throughput: one tick per cycle while the output is not stalled; state advances once per tick
// the pipeline stalls as a whole only while a result waits on the output
// reset: synchronous active low; sequencer idle, clock low, tare offset zero,
// configuration back to defaults; no clearing pass
module load_cell_adc_serial_reader import lcr_pkg::*; #(
    parameter int DATA_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in         i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out        o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [31:0] i_cfg_data
);

    t_cfg                      cfg;
    t_flags                    flags;
    logic signed [DATA_BITS:0] diff;
    logic                      en;
    logic                      accept;
    logic                      r_v1, r_v2, r_v3;

    assign en      = !r_v3 || i_ready;
    assign accept  = i_valid && en;
    assign o_ready = en;
    assign o_valid = r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    lcr_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    lcr_ctrl #(.DATA_BITS(DATA_BITS)) u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_en     (en),
        .i_item   (i_data),
        .i_cfg    (cfg),
        .o_flags  (flags),
        .o_diff   (diff)
    );

    lcr_scale #(.DATA_BITS(DATA_BITS)) u_scale (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_flags (flags),
        .i_diff  (diff),
        .i_scale (cfg.scale_reciprocal),
        .o_data  (o_data)
    );

    a_tmo_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.timed_out |-> o_data.result_valid && o_data.raw_value == 24'sd0)
        else $error("timeout without completion or with nonzero raw");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.result_valid |-> !o_data.busy_res && !o_data.sck_level)
        else $error("completion while busy or clock high");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.result_valid |->
            o_data.raw_value == 24'sd0 && o_data.weight_value == 32'sd0)
        else $error("payload set without completion");

    a_pipe_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(r_v2) || $past(r_v3))
        else $error("result without an accepted tick");

endmodule

// ===== tb/tb.sv =====
// testbench for the load cell reader: a tick table, then state-driven random ticks, all checked
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import lcr_pkg::*;

    localparam int DATA_W      = 24;
    localparam int DIR_N       = 18;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 4;
    localparam int STALL_LIMIT = 4000;
    localparam int ITEM_GOAL   = 450;

    typedef enum logic [1:0] {SEQ_IDLE, SEQ_WAIT, SEQ_HIGH, SEQ_LOW} t_seq;

    typedef struct packed {
        t_in  item;
        logic typed;
        t_out want;
    } t_step_row;

    logic        i_clk      = 1'b0;
    logic        i_rst_n    = 1'b0;
    logic        i_valid    = 1'b0;
    logic        o_ready;
    t_in         i_data     = '0;
    logic        o_valid;
    logic        i_ready    = 1'b0;
    t_out        o_data;
    logic        i_cfg_we   = 1'b0;
    logic [1:0]  i_cfg_idx  = '0;
    logic [31:0] i_cfg_data = '0;

    load_cell_adc_serial_reader dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_data     (o_data),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // predicted reader state
    t_cfg               regs_now  = '{RST_GAIN_PULSES, RST_TIMEOUT_TICKS, RST_HALF_PERIOD,
                                      RST_SCALE_RECIP};
    t_seq               seq       = SEQ_IDLE;
    logic [4:0]         bit_cnt   = '0;
    logic [23:0]        shift_q   = '0;
    logic [19:0]        wait_cnt  = '0;
    logic [7:0]         half_cnt  = '0;
    logic signed [23:0] tare_off  = '0;
    logic               tare_pend = 1'b0;
    logic               sck_q     = 1'b0;

    // stimulus plan for the running conversion
    int          wait_plan = 0;
    logic [23:0] data_word = '0;

    t_out awaited_reports[$];
    int   items_total  = 0;
    int   data_done    = 0;
    int   timeouts     = 0;
    int   tares_done   = 0;
    int   settings     = 0;
    int   reports_seen = 0;
    int   mismatches   = 0;
    int   quiet_cycles = 0;
    bit   send_jitter  = 1'b1;
    bit   recv_jitter  = 1'b1;
    bit   hold_request = 1'b0;

    t_step_row dir_tab [DIR_N];

    function automatic t_out pins(input logic sck, input logic busy);
        t_out r;
        r           = '0;
        r.sck_level = sck;
        r.busy_res  = busy;
        return r;
    endfunction

    function automatic t_step_row step_row(input logic [1:0] act, input logic dout,
                                           input logic typed, input t_out want);
        t_step_row r;
        r.item  = '{act, dout};
        r.typed = typed;
        r.want  = want;
        return r;
    endfunction

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 3);
    endfunction

    function automatic t_out advance_reader(input t_in it);
        t_out               r;
        logic [7:0]         hp;
        logic               done;
        logic               tmo;
        logic signed [23:0] raw;
        logic signed [31:0] wgt;
        longint             prod;
        longint             q;
        hp   = (regs_now.half_period_ticks == 8'd0) ? 8'd1 : regs_now.half_period_ticks;
        done = 1'b0;
        tmo  = 1'b0;
        raw  = '0;
        wgt  = '0;
        case (seq)
            SEQ_IDLE: begin
                if (it.action == ACT_READ || it.action == ACT_TARE) begin
                    seq       = SEQ_WAIT;
                    wait_cnt  = '0;
                    tare_pend = (it.action == ACT_TARE);
                    sck_q     = 1'b0;
                end else if (it.action == ACT_POWER_DOWN) begin
                    sck_q = 1'b1;
                end
            end
            SEQ_WAIT: begin
                if (!it.dout_level) begin
                    seq      = SEQ_HIGH;
                    bit_cnt  = '0;
                    shift_q  = '0;
                    half_cnt = '0;
                    sck_q    = 1'b1;
                end else begin
                    wait_cnt = wait_cnt + 20'd1;
                    if (wait_cnt >= regs_now.timeout_ticks) begin
                        done = 1'b1;
                        tmo  = 1'b1;
                    end
                end
            end
            SEQ_HIGH: begin
                half_cnt = half_cnt + 8'd1;
                if (half_cnt >= hp) begin
                    if (int'(bit_cnt) < DATA_W) shift_q = {shift_q[22:0], it.dout_level};
                    half_cnt = '0;
                    sck_q    = 1'b0;
                    seq      = SEQ_LOW;
                end
            end
            default: begin
                half_cnt = half_cnt + 8'd1;
                if (half_cnt >= hp) begin
                    half_cnt = '0;
                    bit_cnt  = bit_cnt + 5'd1;
                    if (int'(bit_cnt) < DATA_W + int'(regs_now.gain_pulses)) begin
                        sck_q = 1'b1;
                        seq   = SEQ_HIGH;
                    end else begin
                        done = 1'b1;
                        raw  = $signed(shift_q);
                    end
                end
            end
        endcase
        if (done) begin
            seq   = SEQ_IDLE;
            sck_q = 1'b0;
            if (tare_pend) begin
                tare_off = raw;
                tares_done++;
            end
            tare_pend = 1'b0;
            prod = (longint'(raw) - longint'(tare_off))
                   * longint'($signed(regs_now.scale_reciprocal));
            q = prod >>> 16;
            if (q > longint'(WEIGHT_MAX)) wgt = WEIGHT_MAX;
            else if (q < longint'(WEIGHT_MIN)) wgt = WEIGHT_MIN;
            else wgt = 32'(q);
            if (tmo) timeouts++;
            else data_done++;
        end
        r.sck_level    = sck_q;
        r.result_valid = done;
        r.raw_value    = raw;
        r.weight_value = wgt;
        r.timed_out    = tmo;
        r.busy_res     = (seq != SEQ_IDLE);
        return r;
    endfunction

    // picks the next tick from the predicted state so most conversions run to the end
    function automatic t_in next_tick();
        t_in it;
        int  eff_tmo;
        it.dout_level = 1'($urandom_range(0, 1));
        it.action     = ACT_TICK;
        eff_tmo = (regs_now.timeout_ticks == 20'd0) ? 1 : int'(regs_now.timeout_ticks);
        case (seq)
            SEQ_IDLE: begin
                case ($urandom_range(0, 19))
                    0, 1, 2:    it.action = ACT_TICK;
                    3, 4, 5:    it.action = ACT_POWER_DOWN;
                    6, 7, 8, 9: it.action = ACT_TARE;
                    default:    it.action = ACT_READ;
                endcase
                if ($urandom_range(0, 3) == 0 && eff_tmo <= 20) wait_plan = eff_tmo;
                else wait_plan = $urandom_range(0, (eff_tmo - 1 < 6) ? eff_tmo - 1 : 6);
                case ($urandom_range(0, 5))
                    0:       data_word = 24'h000000;
                    1:       data_word = 24'hFFFFFF;
                    2:       data_word = 24'h800000;
                    3:       data_word = 24'h7FFFFF;
                    default: data_word = 24'($urandom);
                endcase
            end
            SEQ_WAIT: begin
                if ($urandom_range(0, 3) == 0) it.action = 2'($urandom_range(0, 3));
                if (wait_plan > 0) begin
                    it.dout_level = 1'b1;
                    wait_plan--;
                end else begin
                    it.dout_level = 1'b0;
                end
            end
            default: begin
                if ($urandom_range(0, 3) == 0) it.action = 2'($urandom_range(0, 3));
                if (int'(bit_cnt) < DATA_W) it.dout_level = data_word[DATA_W - 1 - int'(bit_cnt)];
            end
        endcase
        return it;
    endfunction

    task automatic feed_tick(input t_in item, input logic use_typed, input t_out typed);
        t_out predicted;
        int   gap;
        i_valid <= 1'b1;
        i_data  <= item;
        do @(posedge i_clk); while (!o_ready);
        predicted = advance_reader(item);
        awaited_reports.push_back(use_typed ? typed : predicted);
        items_total++;
        gap = 0;
        if (send_jitter && $urandom_range(0, 3) == 0) gap = gap_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int target);
        int start;
        start = data_done;
        while (data_done - start < target || seq != SEQ_IDLE) feed_tick(next_tick(), 1'b0, '0);
        i_valid <= 1'b0;
    endtask

    task automatic settle_reader();
        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic put_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c, input logic [3:0] sel);
        if (sel[REG_GAIN_PULSES]) begin
            put_reg(REG_GAIN_PULSES, {30'd0, c.gain_pulses});
            regs_now.gain_pulses = c.gain_pulses;
        end
        if (sel[REG_TIMEOUT_TICKS]) begin
            put_reg(REG_TIMEOUT_TICKS, {12'd0, c.timeout_ticks});
            regs_now.timeout_ticks = c.timeout_ticks;
        end
        if (sel[REG_HALF_PERIOD]) begin
            put_reg(REG_HALF_PERIOD, {24'd0, c.half_period_ticks});
            regs_now.half_period_ticks = c.half_period_ticks;
        end
        if (sel[REG_SCALE_RECIP]) begin
            put_reg(REG_SCALE_RECIP, c.scale_reciprocal);
            regs_now.scale_reciprocal = c.scale_reciprocal;
        end
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        settings++;
    endtask

    // output side: random stalls plus one long hold-off on request
    initial begin : drive_ready
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES - 1;
                i_ready <= 1'b0;
            end else if (recv_jitter && $urandom_range(0, 3) == 0) begin
                hold_left = gap_len() - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : check_reports
        t_out want;
        if (i_rst_n && o_valid && i_ready) begin
            if (awaited_reports.size() == 0) begin
                $error("transaction with no expected report: %h", o_data);
                mismatches++;
            end else begin
                want = awaited_reports.pop_front();
                reports_seen++;
                if (o_data.sck_level !== want.sck_level) begin
                    $error("sck_level: expected %0d, got %0d", want.sck_level, o_data.sck_level);
                    mismatches++;
                end
                if (o_data.result_valid !== want.result_valid) begin
                    $error("result_valid: expected %0d, got %0d",
                           want.result_valid, o_data.result_valid);
                    mismatches++;
                end
                if (o_data.raw_value !== want.raw_value) begin
                    $error("raw_value: expected %0d, got %0d", want.raw_value, o_data.raw_value);
                    mismatches++;
                end
                if (o_data.weight_value !== want.weight_value) begin
                    $error("weight_value: expected %0d, got %0d",
                           want.weight_value, o_data.weight_value);
                    mismatches++;
                end
                if (o_data.timed_out !== want.timed_out) begin
                    $error("timed_out: expected %0d, got %0d", want.timed_out, o_data.timed_out);
                    mismatches++;
                end
                if (o_data.busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0d, got %0d", want.busy_res, o_data.busy_res);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == STALL_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        t_cfg c;
        t_out tmo_report;
        int   k;
        tmo_report = '{sck_level: 1'b0, result_valid: 1'b1, raw_value: '0, weight_value: '0,
                       timed_out: 1'b1, busy_res: 1'b0};
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // short ready timeout so the table reaches the timeout path
        c = regs_now;
        c.timeout_ticks = 20'd2;
        program_regs(c, 4'b1 << REG_TIMEOUT_TICKS);

        dir_tab = '{
            step_row(ACT_TICK,       1'b1, 1'b1, pins(1'b0, 1'b0)),
            step_row(ACT_TICK,       1'b0, 1'b1, pins(1'b0, 1'b0)),
            step_row(ACT_POWER_DOWN, 1'b0, 1'b1, pins(1'b1, 1'b0)),
            step_row(ACT_TICK,       1'b1, 1'b1, pins(1'b1, 1'b0)),
            step_row(ACT_READ,       1'b1, 1'b1, pins(1'b0, 1'b1)),
            step_row(ACT_TARE,       1'b1, 1'b0, '0),
            step_row(ACT_POWER_DOWN, 1'b1, 1'b1, tmo_report),
            step_row(ACT_TARE,       1'b0, 1'b1, pins(1'b0, 1'b1)),
            step_row(ACT_TICK,       1'b1, 1'b0, '0),
            step_row(ACT_READ,       1'b1, 1'b1, tmo_report),
            step_row(ACT_POWER_DOWN, 1'b1, 1'b1, pins(1'b1, 1'b0)),
            step_row(ACT_READ,       1'b1, 1'b1, pins(1'b0, 1'b1)),
            step_row(ACT_TICK,       1'b0, 1'b1, pins(1'b1, 1'b1)),
            step_row(ACT_POWER_DOWN, 1'b1, 1'b0, '0),
            step_row(ACT_READ,       1'b0, 1'b0, '0),
            step_row(ACT_TARE,       1'b0, 1'b0, '0),
            step_row(ACT_TICK,       1'b1, 1'b0, '0),
            step_row(ACT_POWER_DOWN, 1'b0, 1'b0, '0)
        };
        for (int i = 0; i < DIR_N; i++) begin
            feed_tick(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].want);
        end

        // first random phase keeps the short timeout and the other reset values, with a long output hold-off
        hold_request = 1'b1;
        run_phase(2);

        for (k = 1; k <= 3 || items_total < ITEM_GOAL; k++) begin
            case (k)
                1: c = '{2'd3, 20'hFFFFF, 8'd2, WEIGHT_MAX};
                2: c = '{2'd0, 20'd0, 8'd0, WEIGHT_MIN};
                3: c = '{2'd2, 20'd1, 8'd1, 32'sd0};
                default: begin
                    c.gain_pulses       = 2'($urandom_range(0, 3));
                    c.timeout_ticks     = 20'($urandom_range(0, 12));
                    c.half_period_ticks = 8'($urandom_range(0, 3));
                    if ($urandom_range(0, 1) == 0) c.scale_reciprocal = $urandom;
                    else c.scale_reciprocal = 32'($urandom_range(0, 262143)) - 32'sd131072;
                end
            endcase
            settle_reader();
            program_regs(c, 4'hF);
            send_jitter = (k % 3 != 0);
            recv_jitter = (k % 3 != 0);
            run_phase(1);
        end

        while (awaited_reports.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("run: %0d ticks, %0d conversions, %0d timeouts, %0d tares", items_total,
                 data_done, timeouts, tares_done);
        $display("run: %0d register settings, %0d reports compared", settings, reports_seen);
        if (mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
